// File: rtl/core/aibm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aibm_pkg
// shared types, constants and register codes for the anchor iou best match unit
// ----------------------------------------------------------------------------
package aibm_pkg;

	localparam int MAX_ANCHORS     = 9;
	localparam int MASK_SLOT_COUNT = 3;

	localparam int ANC_DIM_W  = 10;
	localparam int IDX_W      = 4;
	localparam int NET_W      = 11;
	localparam int TRUTH_W    = 16;
	localparam int PIX_W      = TRUTH_W + NET_W;
	localparam int AREA_W     = 2 * PIX_W;
	localparam int OPD_W      = 28;
	localparam int PROD_W     = 2 * OPD_W;
	localparam int ACC_W      = 2 * PROD_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 60;

	localparam logic [CFG_IDX_W-1:0] REG_ANCHORS_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANCHORS_MID  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANCHORS_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_COUNT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NET_WIDTH    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NET_HEIGHT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_SLOTS   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_COUNT   = 3'd7;

	localparam logic [3:0]       RST_ANCHOR_COUNT = 4'd9;
	localparam logic [NET_W-1:0] RST_NET_WIDTH    = 11'd416;
	localparam logic [NET_W-1:0] RST_NET_HEIGHT   = 11'd416;
	localparam logic [11:0]      RST_MASK_SLOTS   = 12'd2166;
	localparam logic [1:0]       RST_MASK_COUNT   = 2'd3;

	// eight partial products, then a drain step
	localparam logic [3:0] PP_LAST = 4'd8;

	typedef struct packed {
		logic [ANC_DIM_W-1:0] h;
		logic [ANC_DIM_W-1:0] w;
	} anchor_t;

	typedef struct packed {
		anchor_t [MAX_ANCHORS-1:0] anc;
		logic [IDX_W-1:0]          count;
		logic [NET_W-1:0]          net_w;
		logic [NET_W-1:0]          net_h;
		logic [11:0]               mask_slots;
		logic [1:0]                mask_count;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TW,
		ST_TH,
		ST_TA,
		ST_TAREA,
		ST_ANC,
		ST_AB,
		ST_UNI,
		ST_CROSS,
		ST_DEC,
		ST_MASK
	} state_t;

	typedef struct packed {
		state_t           state;
		logic [IDX_W-1:0] n;
		logic [3:0]       pp;
		logic             in_ready;
	} ctrl_t;

endpackage
`default_nettype wire

// File: rtl/core/anchor_iou_best_match_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// anchor_iou_best_match_unit
// best-iou anchor search for one truth box with mask slot lookup
// ----------------------------------------------------------------------------
// One item is taken only while the block is idle. It is then matched
// against every anchor up to the clamped anchor count, and a result is
// offered after the last anchor. All products go through one shared 28 x 28
// multiplier: three for the truth scaling and area, two per anchor
// for intersection and anchor area, and eight partial products per anchor
// for the exact cross-multiplied iou compare. The result sits in an output
// register, so the next item can be accepted while it waits to be taken.
// ----------------------------------------------------------------------------
module anchor_iou_best_match_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// tdata: truth_width[15:0], truth_height[31:16]
	input  wire logic [31:0]                        s_tdata,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// tdata: best_anchor[3:0], in_mask[4], mask_slot[6:5], zero[7]
	output logic [7:0]                              m_tdata,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [aibm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [aibm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int OW = aibm_pkg::OPD_W;
	localparam int PW = aibm_pkg::PROD_W;
	localparam int AW = aibm_pkg::ACC_W;

	aibm_pkg::cfg_t    cfg;
	aibm_pkg::ctrl_t   ctrl;
	aibm_pkg::anchor_t anc_cur;

	logic in_accept;
	logic out_free;

	logic [aibm_pkg::TRUTH_W-1:0] tin_w_q;
	logic [aibm_pkg::TRUTH_W-1:0] tin_h_q;
	logic [aibm_pkg::PIX_W-1:0]   tw_q;
	logic [aibm_pkg::PIX_W-1:0]   th_q;
	logic [aibm_pkg::AREA_W-1:0]  tarea_q;
	logic [PW-1:0]                inter_q;
	logic [PW-1:0]                uni_q;
	logic [PW-1:0]                bi_q;
	logic [PW-1:0]                bu_q;
	logic [AW-1:0]                acc_q;
	logic [aibm_pkg::IDX_W-1:0]   best_q;

	logic [OW-1:0] opd_a;
	logic [OW-1:0] opd_b;
	logic [PW-1:0] prod_q;

	logic [aibm_pkg::PIX_W-1:0] aw_px;
	logic [aibm_pkg::PIX_W-1:0] ah_px;
	logic [aibm_pkg::PIX_W-1:0] iw;
	logic [aibm_pkg::PIX_W-1:0] ih;

	logic [PW-1:0] px;
	logic [PW-1:0] py;
	logic [3:0]    pp_prev;
	logic [AW-1:0] term;
	logic          win;

	logic          found;
	logic [1:0]    slot;
	logic          out_valid_q;
	logic [aibm_pkg::IDX_W-1:0] out_best_q;
	logic          out_in_mask_q;
	logic [1:0]    out_slot_q;

	aibm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	aibm_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.out_free  (out_free),
		.count     (cfg.count),
		.ctrl      (ctrl)
	);

	aibm_mult u_mult (
		.clk    (clk),
		.a      (opd_a),
		.b      (opd_b),
		.prod_q (prod_q)
	);

	assign cfg_ready = 1'b1;
	assign s_tready  = ctrl.in_ready;
	assign in_accept = s_tvalid & s_tready;
	assign out_free  = !out_valid_q || m_tready;

	// anchor geometry in q.16
	always_comb begin
		anc_cur = cfg.anc[ctrl.n];
		aw_px   = {1'b0, anc_cur.w, 16'b0};
		ah_px   = {1'b0, anc_cur.h, 16'b0};
		iw      = (aw_px < tw_q) ? aw_px : tw_q;
		ih      = (ah_px < th_q) ? ah_px : th_q;
	end

	// partial product operand selection
	always_comb begin
		px = ctrl.pp[2] ? bi_q : inter_q;
		py = ctrl.pp[2] ? uni_q : bu_q;
	end

	always_comb begin
		opd_a = '0;
		opd_b = '0;
		case (ctrl.state)
			aibm_pkg::ST_TW: begin
				opd_a = OW'(tin_w_q);
				opd_b = OW'(cfg.net_w);
			end
			aibm_pkg::ST_TH: begin
				opd_a = OW'(tin_h_q);
				opd_b = OW'(cfg.net_h);
			end
			aibm_pkg::ST_TA: begin
				opd_a = OW'(tw_q);
				opd_b = prod_q[OW-1:0];
			end
			aibm_pkg::ST_ANC: begin
				opd_a = OW'(iw);
				opd_b = OW'(ih);
			end
			aibm_pkg::ST_AB: begin
				opd_a = OW'(anc_cur.w);
				opd_b = OW'(anc_cur.h);
			end
			aibm_pkg::ST_CROSS: begin
				opd_a = ctrl.pp[1] ? px[PW-1:OW] : px[OW-1:0];
				opd_b = ctrl.pp[0] ? py[PW-1:OW] : py[OW-1:0];
			end
			default: begin
				opd_a = '0;
				opd_b = '0;
			end
		endcase
	end

	// weight of the partial product now leaving the product register
	always_comb begin
		pp_prev = ctrl.pp - 4'd1;
		case ({1'b0, pp_prev[1]} + {1'b0, pp_prev[0]})
			2'd0:    term = AW'(prod_q);
			2'd1:    term = AW'(prod_q) << OW;
			default: term = AW'(prod_q) << (2 * OW);
		endcase
	end

	assign win = (uni_q != '0) && !acc_q[AW-1] && (acc_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else begin
			if (in_accept) best_q <= '0;
			else if (ctrl.state == aibm_pkg::ST_DEC && win) best_q <= ctrl.n;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			tin_w_q <= s_tdata[15:0];
			tin_h_q <= s_tdata[31:16];
			bi_q    <= '0;
			bu_q    <= PW'(1);
		end
		case (ctrl.state)
			aibm_pkg::ST_TH:    tw_q    <= prod_q[aibm_pkg::PIX_W-1:0];
			aibm_pkg::ST_TA:    th_q    <= prod_q[aibm_pkg::PIX_W-1:0];
			aibm_pkg::ST_TAREA: tarea_q <= prod_q[aibm_pkg::AREA_W-1:0];
			aibm_pkg::ST_AB:    inter_q <= prod_q;
			aibm_pkg::ST_UNI: begin
				uni_q <= {prod_q[PW-33:0], 32'b0} + PW'(tarea_q) - inter_q;
				acc_q <= '0;
			end
			aibm_pkg::ST_CROSS: begin
				if (ctrl.pp != '0) begin
					acc_q <= pp_prev[2] ? (acc_q - term) : (acc_q + term);
				end
			end
			aibm_pkg::ST_DEC: begin
				if (win) begin
					bi_q <= inter_q;
					bu_q <= uni_q;
				end
			end
			default: ;
		endcase
	end

	// first valid mask slot holding the best anchor
	always_comb begin
		found = 1'b0;
		slot  = 2'd3;
		for (int s = aibm_pkg::MASK_SLOT_COUNT - 1; s >= 0; s--) begin
			if ((2'(s) < cfg.mask_count) && (cfg.mask_slots[4*s +: 4] == best_q)) begin
				found = 1'b1;
				slot  = 2'(s);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.state == aibm_pkg::ST_MASK && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.state == aibm_pkg::ST_MASK && out_free) begin
			out_best_q    <= best_q;
			out_in_mask_q <= found;
			out_slot_q    <= slot;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_slot_q, out_in_mask_q, out_best_q};

endmodule
`default_nettype wire

// File: rtl/core/aibm_mult.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aibm_mult
// shared unsigned 28 x 28 multiplier with registered product
// ----------------------------------------------------------------------------
module aibm_mult (
	input  wire logic                         clk,
	input  wire logic [aibm_pkg::OPD_W-1:0]   a,
	input  wire logic [aibm_pkg::OPD_W-1:0]   b,
	output logic      [aibm_pkg::PROD_W-1:0]  prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule
`default_nettype wire

// File: rtl/core/aibm_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aibm_cfg
// configuration register file, write channel decode and count clamping
// ----------------------------------------------------------------------------
module aibm_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               wr_en,
	input  wire logic [aibm_pkg::CFG_IDX_W-1:0]     wr_index,
	input  wire logic [aibm_pkg::CFG_DATA_W-1:0]    wr_data,
	output aibm_pkg::cfg_t                          cfg
);

	logic [aibm_pkg::CFG_DATA_W-1:0] anc_low_q;
	logic [aibm_pkg::CFG_DATA_W-1:0] anc_mid_q;
	logic [aibm_pkg::CFG_DATA_W-1:0] anc_high_q;
	logic [3:0]                      anc_count_q;
	logic [aibm_pkg::NET_W-1:0]      net_w_q;
	logic [aibm_pkg::NET_W-1:0]      net_h_q;
	logic [11:0]                     mask_slots_q;
	logic [1:0]                      mask_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anc_low_q    <= '0;
			anc_mid_q    <= '0;
			anc_high_q   <= '0;
			anc_count_q  <= aibm_pkg::RST_ANCHOR_COUNT;
			net_w_q      <= aibm_pkg::RST_NET_WIDTH;
			net_h_q      <= aibm_pkg::RST_NET_HEIGHT;
			mask_slots_q <= aibm_pkg::RST_MASK_SLOTS;
			mask_count_q <= aibm_pkg::RST_MASK_COUNT;
		end else if (wr_en) begin
			unique case (wr_index)
				aibm_pkg::REG_ANCHORS_LOW:  anc_low_q    <= wr_data;
				aibm_pkg::REG_ANCHORS_MID:  anc_mid_q    <= wr_data;
				aibm_pkg::REG_ANCHORS_HIGH: anc_high_q   <= wr_data;
				aibm_pkg::REG_ANCHOR_COUNT: anc_count_q  <= wr_data[3:0];
				aibm_pkg::REG_NET_WIDTH:    net_w_q      <= wr_data[aibm_pkg::NET_W-1:0];
				aibm_pkg::REG_NET_HEIGHT:   net_h_q      <= wr_data[aibm_pkg::NET_W-1:0];
				aibm_pkg::REG_MASK_SLOTS:   mask_slots_q <= wr_data[11:0];
				aibm_pkg::REG_MASK_COUNT:   mask_count_q <= wr_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.anc        = {anc_high_q, anc_mid_q, anc_low_q};
		cfg.count      = (anc_count_q > 4'(aibm_pkg::MAX_ANCHORS))
		                 ? 4'(aibm_pkg::MAX_ANCHORS) : anc_count_q;
		cfg.net_w      = net_w_q;
		cfg.net_h      = net_h_q;
		cfg.mask_slots = mask_slots_q;
		cfg.mask_count = (mask_count_q > 2'(aibm_pkg::MASK_SLOT_COUNT))
		                 ? 2'(aibm_pkg::MASK_SLOT_COUNT) : mask_count_q;
	end

endmodule
`default_nettype wire

// File: rtl/core/aibm_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aibm_fsm
// sequencer: scaling, per-anchor iou steps, partial product counter, mask lookup
// ----------------------------------------------------------------------------
module aibm_fsm (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_accept,
	input  wire logic                          out_free,
	input  wire logic [aibm_pkg::IDX_W-1:0]    count,
	output aibm_pkg::ctrl_t                    ctrl
);

	aibm_pkg::state_t             state_q;
	aibm_pkg::state_t             state_d;
	logic [aibm_pkg::IDX_W-1:0]   n_q;
	logic [3:0]                   pp_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			aibm_pkg::ST_IDLE:  if (in_accept) state_d = aibm_pkg::ST_TW;
			aibm_pkg::ST_TW:    state_d = aibm_pkg::ST_TH;
			aibm_pkg::ST_TH:    state_d = aibm_pkg::ST_TA;
			aibm_pkg::ST_TA:    state_d = aibm_pkg::ST_TAREA;
			aibm_pkg::ST_TAREA: begin
				state_d = (count == '0) ? aibm_pkg::ST_MASK : aibm_pkg::ST_ANC;
			end
			aibm_pkg::ST_ANC:   state_d = aibm_pkg::ST_AB;
			aibm_pkg::ST_AB:    state_d = aibm_pkg::ST_UNI;
			aibm_pkg::ST_UNI:   state_d = aibm_pkg::ST_CROSS;
			aibm_pkg::ST_CROSS: if (pp_q == aibm_pkg::PP_LAST) state_d = aibm_pkg::ST_DEC;
			aibm_pkg::ST_DEC: begin
				state_d = (n_q + 4'd1 == count) ? aibm_pkg::ST_MASK : aibm_pkg::ST_ANC;
			end
			aibm_pkg::ST_MASK:  if (out_free) state_d = aibm_pkg::ST_IDLE;
			default:            state_d = aibm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aibm_pkg::ST_IDLE;
			n_q     <= '0;
			pp_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == aibm_pkg::ST_IDLE) n_q <= '0;
			else if (state_q == aibm_pkg::ST_DEC) n_q <= n_q + 4'd1;
			if (state_q == aibm_pkg::ST_UNI) pp_q <= '0;
			else if (state_q == aibm_pkg::ST_CROSS) pp_q <= pp_q + 4'd1;
		end
	end

	always_comb begin
		ctrl.state    = state_q;
		ctrl.n        = n_q;
		ctrl.pp       = pp_q;
		ctrl.in_ready = (state_q == aibm_pkg::ST_IDLE);
	end

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stream-level test of the anchor iou best match unit: truth boxes go in,
// each result is checked against a predicted best anchor and mask slot,
// under directed corner settings and randomized register settings
// ----------------------------------------------------------------------------
module tb;

	localparam int LIMIT           = 1_000_000;
	localparam int DRAIN_CYCLES    = 130;
	localparam int RAND_PHASES     = 12;
	localparam int ITEMS_PER_PHASE = 75;

	localparam int YOLO_W [9] = '{10, 16, 33, 30, 62, 59, 116, 156, 373};
	localparam int YOLO_H [9] = '{13, 30, 23, 61, 45, 119, 90, 198, 326};

	typedef struct packed {
		logic [aibm_pkg::IDX_W-1:0] best;
		logic                       hit;
		logic [1:0]                 slot;
	} match_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	// tdata: truth_width[15:0], truth_height[31:16]
	logic [31:0]                     s_tdata   = '0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	// tdata: best_anchor[3:0], in_mask[4], mask_slot[6:5], zero[7]
	logic [7:0]                      m_tdata;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [aibm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [aibm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	// register shadow
	logic [aibm_pkg::CFG_DATA_W-1:0] anc_word [3];
	logic [aibm_pkg::IDX_W-1:0]      anc_count;
	logic [aibm_pkg::NET_W-1:0]      net_w;
	logic [aibm_pkg::NET_W-1:0]      net_h;
	logic [11:0]                     slot_word;
	logic [1:0]                      slot_count;

	match_t expected_matches [$];
	int     errors       = 0;
	int     mismatches   = 0;
	int     boxes_sent   = 0;
	int     matches_seen = 0;
	int     reg_writes   = 0;
	int     cycles       = 0;
	bit     calm         = 1'b0;

	anchor_iou_best_match_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	function automatic match_t predict_match(logic [15:0] tw_q, logic [15:0] th_q);
		logic [63:0]                     tw, th, tarea, aw, ah, iw, ih, inter, uni;
		logic [63:0]                     best_inter, best_uni;
		logic [127:0]                    lhs, rhs;
		logic [aibm_pkg::CFG_DATA_W-1:0] word;
		int                              lim, mlim, sh;
		match_t                          m;
		tw = 64'(tw_q) * 64'(net_w);
		th = 64'(th_q) * 64'(net_h);
		tarea = tw * th;
		lim = (anc_count > aibm_pkg::MAX_ANCHORS) ? aibm_pkg::MAX_ANCHORS : int'(anc_count);
		best_inter = '0;
		best_uni = 64'd1;
		m = '{best: '0, hit: 1'b0, slot: 2'd3};
		for (int n = 0; n < lim; n++) begin
			word = anc_word[n / 3];
			sh = (n % 3) * 20;
			aw = 64'(word[sh +: aibm_pkg::ANC_DIM_W]) << 16;
			ah = 64'(word[sh + aibm_pkg::ANC_DIM_W +: aibm_pkg::ANC_DIM_W]) << 16;
			iw = (aw < tw) ? aw : tw;
			ih = (ah < th) ? ah : th;
			inter = iw * ih;
			uni = aw * ah + tarea - inter;
			lhs = 128'(inter) * 128'(best_uni);
			rhs = 128'(best_inter) * 128'(uni);
			if (uni != 0 && lhs > rhs) begin
				best_inter = inter;
				best_uni = uni;
				m.best = aibm_pkg::IDX_W'(n);
			end
		end
		mlim = (slot_count > aibm_pkg::MASK_SLOT_COUNT) ? aibm_pkg::MASK_SLOT_COUNT
			: int'(slot_count);
		// walk down so the lowest matching slot is kept
		for (int s = mlim - 1; s >= 0; s--) begin
			if (slot_word[4*s +: 4] == m.best) begin
				m.hit = 1'b1;
				m.slot = 2'(s);
			end
		end
		return m;
	endfunction

	function automatic void apply_reg(logic [aibm_pkg::CFG_IDX_W-1:0] idx,
		logic [aibm_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			aibm_pkg::REG_ANCHORS_LOW:  anc_word[0] = data;
			aibm_pkg::REG_ANCHORS_MID:  anc_word[1] = data;
			aibm_pkg::REG_ANCHORS_HIGH: anc_word[2] = data;
			aibm_pkg::REG_ANCHOR_COUNT: anc_count = data[aibm_pkg::IDX_W-1:0];
			aibm_pkg::REG_NET_WIDTH:    net_w = data[aibm_pkg::NET_W-1:0];
			aibm_pkg::REG_NET_HEIGHT:   net_h = data[aibm_pkg::NET_W-1:0];
			aibm_pkg::REG_MASK_SLOTS:   slot_word = data[11:0];
			aibm_pkg::REG_MASK_COUNT:   slot_count = data[1:0];
			default: ;
		endcase
	endfunction

	function automatic logic [aibm_pkg::CFG_DATA_W-1:0] yolo_group(int g);
		logic [aibm_pkg::CFG_DATA_W-1:0] word;
		word = '0;
		for (int k = 0; k < 3; k++)
			word[20*k +: 20] = {10'(YOLO_H[3*g+k]), 10'(YOLO_W[3*g+k])};
		return word;
	endfunction

	function automatic int near_size(int dim, logic [aibm_pkg::NET_W-1:0] net);
		int v;
		if (net == 0)
			return int'($urandom_range(0, 65535));
		v = (dim * 65536) / int'(net) + int'($urandom_range(0, 600)) - 300;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v;
	endfunction

	// last write of a group drops valid
	task automatic write_reg(logic [aibm_pkg::CFG_IDX_W-1:0] idx,
		logic [aibm_pkg::CFG_DATA_W-1:0] data, bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_reg(idx, data);
		reg_writes++;
		if (last)
			cfg_valid <= 1'b0;
	endtask

	task automatic send_box(logic [15:0] w, logic [15:0] h);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {h, w};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_matches = {expected_matches, predict_match(w, h)};
		boxes_sent++;
	endtask

	// truth box that exactly matches a standard anchor at a 1024 network
	task automatic send_yolo(int n);
		send_box(16'(YOLO_W[n] * 64), 16'(YOLO_H[n] * 64));
	endtask

	task automatic settle_block();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_matches.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_reset_state();
		send_box(16'h0000, 16'h0000);
		send_box(16'hFFFF, 16'hFFFF);
		send_box(16'h8000, 16'h1234);
	endtask

	task automatic test_exact_anchors();
		settle_block();
		write_reg(aibm_pkg::REG_ANCHORS_LOW, yolo_group(0), 1'b0);
		write_reg(aibm_pkg::REG_ANCHORS_MID, yolo_group(1), 1'b0);
		write_reg(aibm_pkg::REG_ANCHORS_HIGH, yolo_group(2), 1'b0);
		write_reg(aibm_pkg::REG_ANCHOR_COUNT,
			aibm_pkg::CFG_DATA_W'(aibm_pkg::MAX_ANCHORS), 1'b0);
		write_reg(aibm_pkg::REG_NET_WIDTH, aibm_pkg::CFG_DATA_W'(1024), 1'b0);
		write_reg(aibm_pkg::REG_NET_HEIGHT, aibm_pkg::CFG_DATA_W'(1024), 1'b0);
		write_reg(aibm_pkg::REG_MASK_SLOTS,
			aibm_pkg::CFG_DATA_W'(aibm_pkg::RST_MASK_SLOTS), 1'b0);
		write_reg(aibm_pkg::REG_MASK_COUNT,
			aibm_pkg::CFG_DATA_W'(aibm_pkg::MASK_SLOT_COUNT), 1'b1);
		for (int n = 0; n < aibm_pkg::MAX_ANCHORS; n++)
			send_yolo(n);
		send_box(16'hFFFF, 16'hFFFF);
		send_box(16'hFFFF, 16'h0000);
	endtask

	task automatic test_corner_cases();
		// equal anchors one and two: the lower index takes the tie
		settle_block();
		write_reg(aibm_pkg::REG_ANCHORS_LOW, aibm_pkg::CFG_DATA_W'(
			{10'd100, 10'd100, 10'd100, 10'd100, 10'd10, 10'd10}), 1'b1);
		send_box(16'd6400, 16'd6400);
		// zero-size anchor against an empty truth box has no union
		settle_block();
		write_reg(aibm_pkg::REG_ANCHORS_LOW, aibm_pkg::CFG_DATA_W'(
			{10'd100, 10'd100, 10'd100, 10'd100, 10'd0, 10'd0}), 1'b1);
		send_box(16'h0000, 16'h0000);
		send_box(16'h0000, 16'hFFFF);
		// nothing searched
		settle_block();
		write_reg(aibm_pkg::REG_ANCHORS_LOW, yolo_group(0), 1'b0);
		write_reg(aibm_pkg::REG_ANCHOR_COUNT, '0, 1'b1);
		send_yolo(7);
		// count past the last anchor is clamped
		settle_block();
		write_reg(aibm_pkg::REG_ANCHOR_COUNT, aibm_pkg::CFG_DATA_W'(15), 1'b1);
		send_yolo(8);
		send_yolo(3);
		// out-of-range slot never matches, repeated slot reports the first
		settle_block();
		write_reg(aibm_pkg::REG_MASK_SLOTS,
			aibm_pkg::CFG_DATA_W'({4'd7, 4'd7, 4'd15}), 1'b1);
		send_yolo(7);
		send_yolo(8);
		// no valid slot, then a single slot
		settle_block();
		write_reg(aibm_pkg::REG_MASK_COUNT, '0, 1'b1);
		send_yolo(7);
		settle_block();
		write_reg(aibm_pkg::REG_MASK_COUNT, aibm_pkg::CFG_DATA_W'(1), 1'b0);
		write_reg(aibm_pkg::REG_MASK_SLOTS,
			aibm_pkg::CFG_DATA_W'({4'd0, 4'd0, 4'd7}), 1'b1);
		send_yolo(7);
		// zero network width empties the truth box
		settle_block();
		write_reg(aibm_pkg::REG_NET_WIDTH, '0, 1'b0);
		write_reg(aibm_pkg::REG_NET_HEIGHT, aibm_pkg::CFG_DATA_W'(2047), 1'b1);
		send_box(16'hFFFF, 16'hFFFF);
		send_box(16'h1234, 16'h5678);
	endtask

	task automatic randomize_settings(int p);
		logic [aibm_pkg::CFG_DATA_W-1:0] word [3];
		logic [aibm_pkg::CFG_DATA_W-1:0] junk;
		logic [19:0]                     anc;
		logic [11:0]                     slots;
		logic [aibm_pkg::IDX_W-1:0]      cnt;
		logic [aibm_pkg::NET_W-1:0]      nw, nh;
		logic [1:0]                      mcnt;
		for (int g = 0; g < 3; g++) begin
			for (int k = 0; k < 3; k++) begin
				case ($urandom_range(0, 15))
					0: anc = '0;
					1: anc = {10'd1023, 10'd1023};
					2: anc = {10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023))};
					default: anc = {10'($urandom_range(1, 400)), 10'($urandom_range(1, 400))};
				endcase
				if (p == 0 && $urandom_range(0, 2) == 0)
					anc = {10'd1023, 10'($urandom_range(1, 1023))};
				// duplicate of anchor 0 to force ties
				if ((g != 0 || k != 0) && $urandom_range(0, 9) == 0)
					anc = word[0][19:0];
				word[g][20*k +: 20] = anc;
			end
		end
		if (p == 0)
			cnt = aibm_pkg::IDX_W'(aibm_pkg::MAX_ANCHORS);
		else if (p == 1)
			cnt = aibm_pkg::IDX_W'(1);
		else if ($urandom_range(0, 7) == 0)
			cnt = aibm_pkg::IDX_W'($urandom_range(0, 15));
		else
			cnt = aibm_pkg::IDX_W'($urandom_range(1, aibm_pkg::MAX_ANCHORS));
		case (p)
			0: begin
				nw = 11'd2047;
				nh = 11'd2047;
			end
			1: begin
				nw = 11'd1;
				nh = 11'd1;
			end
			default: begin
				nw = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(1, 2047))
					: 11'($urandom_range(64, 1024));
				nh = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(1, 2047))
					: 11'($urandom_range(64, 1024));
			end
		endcase
		for (int s = 0; s < aibm_pkg::MASK_SLOT_COUNT; s++)
			slots[4*s +: 4] = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(0, 8));
		mcnt = (p == 0) ? 2'd3 : (p == 1) ? 2'd1 : 2'($urandom_range(0, 3));
		// unused upper data bits carry noise on some writes
		junk = ($urandom_range(0, 1) != 0)
			? aibm_pkg::CFG_DATA_W'({$urandom, $urandom}) : '0;
		write_reg(aibm_pkg::REG_ANCHORS_LOW, word[0], 1'b0);
		write_reg(aibm_pkg::REG_ANCHORS_MID, word[1], 1'b0);
		write_reg(aibm_pkg::REG_ANCHORS_HIGH, word[2], 1'b0);
		write_reg(aibm_pkg::REG_ANCHOR_COUNT,
			(junk << aibm_pkg::IDX_W) | aibm_pkg::CFG_DATA_W'(cnt), 1'b0);
		write_reg(aibm_pkg::REG_NET_WIDTH,
			(junk << aibm_pkg::NET_W) | aibm_pkg::CFG_DATA_W'(nw), 1'b0);
		write_reg(aibm_pkg::REG_NET_HEIGHT,
			(junk << aibm_pkg::NET_W) | aibm_pkg::CFG_DATA_W'(nh), 1'b0);
		write_reg(aibm_pkg::REG_MASK_SLOTS,
			(junk << 12) | aibm_pkg::CFG_DATA_W'(slots), 1'b0);
		write_reg(aibm_pkg::REG_MASK_COUNT,
			(junk << 2) | aibm_pkg::CFG_DATA_W'(mcnt), 1'b1);
	endtask

	task automatic send_random_box();
		int lim, n, w, h, sh;
		case ($urandom_range(0, 9))
			0, 1: begin
				w = int'($urandom_range(0, 65535));
				h = int'($urandom_range(0, 65535));
			end
			2: begin
				w = ($urandom_range(0, 1) != 0) ? 65535 : int'($urandom_range(0, 1));
				h = ($urandom_range(0, 1) != 0) ? 65535 : int'($urandom_range(0, 1));
			end
			default: begin
				// near one of the searched anchors
				lim = (anc_count > aibm_pkg::MAX_ANCHORS) ? aibm_pkg::MAX_ANCHORS
					: int'(anc_count);
				if (lim == 0)
					lim = 1;
				n = int'($urandom_range(0, lim - 1));
				sh = (n % 3) * 20;
				w = near_size(int'(anc_word[n / 3][sh +: aibm_pkg::ANC_DIM_W]), net_w);
				h = near_size(int'(anc_word[n / 3][sh + aibm_pkg::ANC_DIM_W +:
					aibm_pkg::ANC_DIM_W]), net_h);
			end
		endcase
		send_box(16'(w), 16'(h));
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < RAND_PHASES; p++) begin
			settle_block();
			calm = (p >= RAND_PHASES - 2);
			randomize_settings(p);
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_random_box();
		end
	endtask

	// result side stalls
	initial begin
		@(posedge arst_n);
		forever begin
			if (calm || $urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		match_t got;
		match_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[3:0], m_tdata[4], m_tdata[6:5]};
			matches_seen++;
			if (expected_matches.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: best %0d in_mask %0d slot %0d",
						got.best, got.hit, got.slot);
			end else begin
				want = expected_matches.pop_front();
				if (got.best !== want.best || got.hit !== want.hit || got.slot !== want.slot) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected best %0d in_mask %0d slot %0d, got best %0d in_mask %0d slot %0d",
							want.best, want.hit, want.slot, got.best, got.hit, got.slot);
				end
			end
		end
	end

	initial begin
		anc_word[0] = '0;
		anc_word[1] = '0;
		anc_word[2] = '0;
		anc_count = aibm_pkg::RST_ANCHOR_COUNT;
		net_w = aibm_pkg::RST_NET_WIDTH;
		net_h = aibm_pkg::RST_NET_HEIGHT;
		slot_word = aibm_pkg::RST_MASK_SLOTS;
		slot_count = aibm_pkg::RST_MASK_COUNT;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_exact_anchors();
		test_corner_cases();
		test_random_settings();
		settle_block();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d truth boxes through %0d register writes and %0d random settings",
			boxes_sent, reg_writes, RAND_PHASES);
		$display("checked %0d results, %0d failures", matches_seen, errors);
		if (errors == 0 && expected_matches.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
